### hw/rtl/ltvd_pkg.sv
// ----------------------------------------------------------------------------
// ltvd_pkg
// Widths, codes and pipeline record types for the line to vertical axis
// distance unit.
// ----------------------------------------------------------------------------
package ltvd_pkg;

  localparam int POS_W   = 20;
  localparam int DIR_W   = 16;
  localparam int DIST_W  = 20;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 3;

  localparam int DIFF_W  = POS_W + 1;        // target minus track point
  localparam int PROD_W  = DIR_W + DIFF_W;   // dir times offset
  localparam int TRAW_W  = PROD_W + 1;       // projection before clamp
  localparam int T_W     = PROD_W;           // clamped projection, unsigned
  localparam int S2_W    = 2 * DIR_W;        // dx^2 + dy^2, unsigned
  localparam int MAG_W   = DIR_W + T_W;      // |d_i| * T
  localparam int NUM_W   = MAG_W + 1;        // plus rounding half
  localparam int Q_W     = 37;               // quotient bits, one per stage
  localparam int REM_W   = S2_W;
  localparam int QXY_W   = 22;               // x-y quotient magnitude bits used
  localparam int CXY_W   = QXY_W + 1;
  localparam int CZ_W    = Q_W + 2;
  localparam int E_W     = CXY_W + 1;
  localparam int SQ_W    = 2 * E_W;
  localparam int RT_W    = SQ_W / 2;         // root bits, one per stage

  localparam int POS_LIMIT  = 307200;
  localparam int ROPE_UNITS = 6410;
  localparam int DIST_MAX   = (1 << DIST_W) - 1;

  typedef enum logic [STAT_W-1:0] {
    ST_VERTICAL     = 2'd0,
    ST_GENERAL      = 2'd1,
    ST_ABOVE_TOP    = 2'd2,
    ST_BELOW_BOTTOM = 2'd3
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_AXIS_X   = 3'd0,
    REG_AXIS_Y   = 3'd1,
    REG_TOP_Z    = 3'd2,
    REG_BOTTOM_Z = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [S2_W-1:0]         den;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [2:0]              neg;
    logic                    vert;
  } div_side_t;

  typedef struct packed {
    status_t                 status;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
  } sq_side_t;

  typedef struct packed {
    logic [DIST_W-1:0]       distance;
    status_t                 status;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
  } res_t;

endpackage

### hw/rtl/ltvd_intf.sv
// ----------------------------------------------------------------------------
// ltvd channel interfaces
// Track request, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ltvd_in_if;
  import ltvd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic                    use_shifted_center;
  modport source(output valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                 use_shifted_center, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
               use_shifted_center, output ready);
endinterface

interface ltvd_out_if;
  import ltvd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DIST_W-1:0]       distance;
  logic [STAT_W-1:0]       status_code;
  logic signed [POS_W-1:0] closest_x;
  logic signed [POS_W-1:0] closest_y;
  logic signed [POS_W-1:0] closest_z;
  modport source(output valid, distance, status_code, closest_x, closest_y,
                 closest_z, input ready);
  modport sink(input valid, distance, status_code, closest_x, closest_y,
               closest_z, output ready);
endinterface

interface ltvd_cfg_if;
  import ltvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [POS_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/line_to_vertical_axis_distance_unit.sv
// ----------------------------------------------------------------------------
// line_to_vertical_axis_distance_unit
// Closest approach of a straight track to a vertical counter axis, with
// status and x-y distance to the top axis.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// in_if   | in  | track point, direction, target select
// out_if  | out | distance, status, closest point
// cfg_if  | in  | register index and data, always ready
//
// One request per cycle while the output queue is not full. The path from
// request to result runs through 37 divider stages (one quotient bit each),
// 24 root stages and the output queue write.
// Reset clears valid bits, queue and registers; no clearing pass.
// A full two-entry output queue holds the whole pipeline and drops in_if.ready.
// ----------------------------------------------------------------------------
module line_to_vertical_axis_distance_unit (
  input logic          clk,
  input logic          rst_n,
  ltvd_in_if.sink      in_if,
  ltvd_out_if.source   out_if,
  ltvd_cfg_if.sink     cfg_if
);
  import ltvd_pkg::*;

  function automatic logic [REM_W+Q_W-1:0] div_step(
    input logic [REM_W-1:0] rem, input logic [Q_W-1:0] nq,
    input logic [S2_W-1:0] den);
    logic [REM_W:0] sh;
    logic           qb;
    logic [REM_W-1:0] rn;
    sh = {rem, nq[Q_W-1]};
    qb = (sh >= {1'b0, den});
    rn = qb ? REM_W'(sh - {1'b0, den}) : sh[REM_W-1:0];
    return {rn, nq[Q_W-2:0], qb};
  endfunction

  // registers
  logic signed [POS_W-1:0] axis_x_r, axis_y_r, top_z_r, bottom_z_r;
  logic signed [POS_W-1:0] center_x_r, center_y_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= '0; axis_y_r <= '0; top_z_r <= '0;
      bottom_z_r <= '0; center_x_r <= '0; center_y_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_AXIS_X:   axis_x_r   <= cfg_if.data;
        REG_AXIS_Y:   axis_y_r   <= cfg_if.data;
        REG_TOP_Z:    top_z_r    <= cfg_if.data;
        REG_BOTTOM_Z: bottom_z_r <= cfg_if.data;
        REG_CENTER_X: center_x_r <= cfg_if.data;
        REG_CENTER_Y: center_y_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // global advance
  logic [1:0] cnt_r;
  logic       en;
  assign en = (cnt_r != 2'd2);
  assign in_if.ready = en;

  // stage 1: offsets and products
  logic signed [POS_W-1:0]  tx, ty;
  logic signed [DIFF_W-1:0] ax, ay;
  logic signed [S2_W-1:0]   dxdx, dydy;
  logic signed [PROD_W-1:0] pa, pb;
  assign tx = in_if.use_shifted_center ? center_x_r : axis_x_r;
  assign ty = in_if.use_shifted_center ? center_y_r : axis_y_r;
  assign ax = DIFF_W'(tx) - DIFF_W'(in_if.pos_x);
  assign ay = DIFF_W'(ty) - DIFF_W'(in_if.pos_y);
  assign dxdx = in_if.dir_x * in_if.dir_x;
  assign dydy = in_if.dir_y * in_if.dir_y;
  assign pa = in_if.dir_x * ax;
  assign pb = in_if.dir_y * ay;

  logic                     s1_v_r;
  logic [S2_W-1:0]          s1_dxdx_r, s1_dydy_r;
  logic signed [PROD_W-1:0] s1_pa_r, s1_pb_r;
  logic signed [DIR_W-1:0]  s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [POS_W-1:0]  s1_px_r, s1_py_r, s1_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_if.valid;
    if (en) begin
      s1_dxdx_r <= dxdx; s1_dydy_r <= dydy;
      s1_pa_r <= pa; s1_pb_r <= pb;
      s1_dx_r <= in_if.dir_x; s1_dy_r <= in_if.dir_y; s1_dz_r <= in_if.dir_z;
      s1_px_r <= in_if.pos_x; s1_py_r <= in_if.pos_y; s1_pz_r <= in_if.pos_z;
    end
  end

  // stage 2: projection, clamp, divisor
  logic                     s1_vert;
  logic signed [TRAW_W-1:0] traw;
  logic [T_W-1:0]           t2;
  logic [S2_W-1:0]          s2;
  assign s1_vert = (s1_dx_r == '0) && (s1_dy_r == '0);
  assign traw = TRAW_W'(s1_pa_r) + TRAW_W'(s1_pb_r);
  assign t2 = (s1_vert || traw[TRAW_W-1]) ? '0 : traw[T_W-1:0];
  assign s2 = s1_dxdx_r + s1_dydy_r;

  logic                 s2_v_r;
  logic [T_W-1:0]       s2_t_r;
  logic [DIR_W-1:0]     s2_ad_r [3];
  div_side_t            s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_t_r <= t2;
      s2_ad_r[0] <= s1_dx_r[DIR_W-1] ? DIR_W'(-s1_dx_r) : s1_dx_r;
      s2_ad_r[1] <= s1_dy_r[DIR_W-1] ? DIR_W'(-s1_dy_r) : s1_dy_r;
      s2_ad_r[2] <= s1_dz_r[DIR_W-1] ? DIR_W'(-s1_dz_r) : s1_dz_r;
      s2_side_r.den  <= s1_vert ? S2_W'(1) : s2;
      s2_side_r.px   <= s1_px_r;
      s2_side_r.py   <= s1_py_r;
      s2_side_r.pz   <= s1_pz_r;
      s2_side_r.neg  <= {s1_dz_r[DIR_W-1], s1_dy_r[DIR_W-1], s1_dx_r[DIR_W-1]};
      s2_side_r.vert <= s1_vert;
    end
  end

  // stage 3: numerator magnitudes
  logic            s3_v_r;
  logic [MAG_W-1:0] s3_mag_r [3];
  div_side_t       s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
    if (en) begin
      for (int i = 0; i < 3; i++) s3_mag_r[i] <= s2_ad_r[i] * s2_t_r;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4 and divider: one quotient bit per stage
  logic             dv_v_r   [Q_W+1];
  logic [REM_W-1:0] dv_rem_r [Q_W+1][3];
  logic [Q_W-1:0]   dv_nq_r  [Q_W+1][3];
  div_side_t        dv_side_r[Q_W+1];
  logic [NUM_W-1:0] num [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      num[i] = NUM_W'(s3_mag_r[i]) + NUM_W'(s3_side_r.den >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= s3_v_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= REM_W'(num[i][NUM_W-1:Q_W]);
        dv_nq_r[0][i]  <= num[i][Q_W-1:0];
      end
      dv_side_r[0] <= s3_side_r;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= dv_v_r[k];
      if (en) begin
        for (int i = 0; i < 3; i++)
          {dv_rem_r[k+1][i], dv_nq_r[k+1][i]} <=
            div_step(dv_rem_r[k][i], dv_nq_r[k][i], dv_side_r[k].den);
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // stage 5: closest point
  div_side_t              dq;
  logic signed [CXY_W-1:0] qx, qy;
  logic signed [CZ_W-1:0]  qz;
  assign dq = dv_side_r[Q_W];
  assign qx = {1'b0, dv_nq_r[Q_W][0][QXY_W-1:0]};
  assign qy = {1'b0, dv_nq_r[Q_W][1][QXY_W-1:0]};
  assign qz = CZ_W'(dv_nq_r[Q_W][2]);

  logic                    s5_v_r, s5_vert_r;
  logic signed [CXY_W-1:0] s5_cx_r, s5_cy_r;
  logic signed [CZ_W-1:0]  s5_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= dv_v_r[Q_W];
    if (en) begin
      s5_cx_r <= CXY_W'(dq.px) + (dq.neg[0] ? -qx : qx);
      s5_cy_r <= CXY_W'(dq.py) + (dq.neg[1] ? -qy : qy);
      s5_cz_r <= CZ_W'(dq.pz) + (dq.neg[2] ? -qz : qz);
      s5_vert_r <= dq.vert;
    end
  end

  // stage 6: squares, status, saturation
  logic signed [E_W-1:0]  ex, ey;
  logic signed [SQ_W-1:0] ex2, ey2;
  status_t                st6;
  assign ex = E_W'(s5_cx_r) - E_W'(axis_x_r);
  assign ey = E_W'(s5_cy_r) - E_W'(axis_y_r);
  assign ex2 = ex * ex;
  assign ey2 = ey * ey;

  always_comb begin
    st6 = s5_vert_r ? ST_VERTICAL : ST_GENERAL;
    if (s5_cz_r > CZ_W'(top_z_r)) st6 = ST_ABOVE_TOP;
    if (s5_cz_r < CZ_W'(bottom_z_r) - CZ_W'(ROPE_UNITS)) st6 = ST_BELOW_BOTTOM;
  end

  logic                   s6_v_r;
  logic [SQ_W-1:0]        s6_ex2_r, s6_ey2_r;
  sq_side_t               s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
    if (en) begin
      s6_ex2_r <= ex2;
      s6_ey2_r <= ey2;
      s6_side_r.status <= st6;
      s6_side_r.cx <= (s5_cx_r > CXY_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) :
                      (s5_cx_r < -CXY_W'(POS_LIMIT)) ? POS_W'(-POS_LIMIT) :
                      s5_cx_r[POS_W-1:0];
      s6_side_r.cy <= (s5_cy_r > CXY_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) :
                      (s5_cy_r < -CXY_W'(POS_LIMIT)) ? POS_W'(-POS_LIMIT) :
                      s5_cy_r[POS_W-1:0];
      s6_side_r.cz <= (s5_cz_r > CZ_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) :
                      (s5_cz_r < -CZ_W'(POS_LIMIT)) ? POS_W'(-POS_LIMIT) :
                      s5_cz_r[POS_W-1:0];
    end
  end

  // stage 7 and root: one root bit per stage
  logic            sq_v_r   [RT_W+1];
  logic [SQ_W-1:0] sq_n_r   [RT_W+1];
  logic [SQ_W-1:0] sq_r_r   [RT_W+1];
  sq_side_t        sq_side_r[RT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s6_v_r;
    if (en) begin
      sq_n_r[0] <= s6_ex2_r + s6_ey2_r;
      sq_r_r[0] <= '0;
      sq_side_r[0] <= s6_side_r;
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W:0] trial;
    logic          take;
    assign trial = {1'b0, sq_r_r[k]} + {1'b0, BIT};
    assign take  = ({1'b0, sq_n_r[k]} >= trial);
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
      if (en) begin
        sq_n_r[k+1] <= take ? SQ_W'({1'b0, sq_n_r[k]} - trial) : sq_n_r[k];
        sq_r_r[k+1] <= take ? (sq_r_r[k] >> 1) + BIT : sq_r_r[k] >> 1;
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  end

  // round, saturate, queue
  logic [RT_W:0] rnd;
  res_t          res;
  assign rnd = (RT_W+1)'(sq_r_r[RT_W]) +
               (RT_W+1)'(sq_n_r[RT_W] > sq_r_r[RT_W]);
  assign res.distance = (rnd > (RT_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                    : rnd[DIST_W-1:0];
  assign res.status = sq_side_r[RT_W].status;
  assign res.cx = sq_side_r[RT_W].cx;
  assign res.cy = sq_side_r[RT_W].cy;
  assign res.cz = sq_side_r[RT_W].cz;

  res_t fifo_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic push, pop;
  assign push = en && sq_v_r[RT_W];
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wr_ptr_r <= 1'b0; rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) fifo_r[wr_ptr_r] <= res;
  end

  assign out_if.valid       = (cnt_r != 2'd0);
  assign out_if.distance    = fifo_r[rd_ptr_r].distance;
  assign out_if.status_code = fifo_r[rd_ptr_r].status;
  assign out_if.closest_x   = fifo_r[rd_ptr_r].cx;
  assign out_if.closest_y   = fifo_r[rd_ptr_r].cy;
  assign out_if.closest_z   = fifo_r[rd_ptr_r].cz;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output queue overflow");
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_if.ready) else $error("accept while queue full");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd0) || (cnt_r == 2'd2)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_v_r[RT_W]) && $stable(s1_v_r))
    else $error("pipeline moved while held");

endmodule
